// ----- sv/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsdf_pkg;

    localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OPCODE     = 3'd1;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd2;
    localparam logic [2:0] ERR_UNMASKED   = 3'd3;
    localparam logic [2:0] ERR_NO_START   = 3'd4;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [3:0] frame_opcode;
        logic       frame_final;
        logic       is_binary;
        logic       last_of_frame;
        logic [2:0] error_code;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/wsdf_if.sv -----
// Handshake channel interfaces for received bytes, results and configuration.
`default_nettype none

interface wsdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsdf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       frame_final;
    logic       is_binary;
    logic       last_of_frame;
    logic [2:0] error_code;

    modport source (output valid, output kind, output data_byte, output frame_opcode,
                    output frame_final, output is_binary, output last_of_frame,
                    output error_code, input ready);
    modport sink (input valid, input kind, input data_byte, input frame_opcode,
                  input frame_final, input is_binary, input last_of_frame,
                  input error_code, output ready);
endinterface

interface wsdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_frame_size;

    modport source (output valid, output max_frame_size, input ready);
    modport sink (input valid, input max_frame_size, output ready);
endinterface

`default_nettype wire

// ----- sv/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer.
//
// Channel  Direction  Request
// rx       in         one received byte of the frame stream
// res      out        one payload byte, empty-frame marker or error
// cfg      in         new value of max_frame_size
//
// One byte is accepted every cycle unless the result register stalls; an accepted byte
// passes the input register and then the header parser, whose result goes to the result register.
// Reset clears the parser state, the fragment context, the halt flag and sets
// max_frame_size to 65536. A stalled result holds the output register; the input
// register then fills and rx.ready falls. After an error every byte is taken and dropped.
`default_nettype none

module websocket_frame_deframer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wsdf_in_if.sink     rx,
    wsdf_out_if.source  res,
    wsdf_cfg_if.sink    cfg
);

    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              can_take;
    logic              advance;
    logic              fire;
    wsdf_pkg::result_t result;

    assign advance = byte_valid && can_take;

    wsdf_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    wsdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .byte_data (byte_data),
        .fire      (fire),
        .result    (result)
    );

    wsdf_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .result   (result),
        .can_take (can_take),
        .res      (res)
    );

endmodule

`default_nettype wire

// ----- sv/wsdf_in_stage.sv -----
// Input register that holds one received byte until the parser takes it.
`default_nettype none

module wsdf_in_stage (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wsdf_in_if.sink     rx,
    input  wire logic   advance,
    output logic        byte_valid,
    output logic [7:0]  byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign rx.ready   = !valid_reg || advance;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb
    begin
        if (rx.valid && rx.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            data_reg <= rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsdf_parser.sv -----
// Frame header parser, fragment context and payload unmasking for one byte a cycle while advance is high.
`default_nettype none

module wsdf_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    wsdf_cfg_if.sink             cfg,
    input  wire logic            advance,
    input  wire logic [7:0]      byte_data,
    output logic                 fire,
    output wsdf_pkg::result_t    result
);

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] max_frame_reg;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [3:0]  len_left_reg, len_left_next;
    logic [63:0] length_reg, length_next;
    logic [63:0] remaining_reg, remaining_next;
    logic        mask_present_reg, mask_present_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [2:0]  mask_left_reg, mask_left_next;
    logic [1:0]  mask_index_reg, mask_index_next;
    logic [3:0]  header_size_reg, header_size_next;
    logic        frag_active_reg, frag_active_next;
    logic        frag_binary_reg, frag_binary_next;
    logic [31:0] frag_mask_reg, frag_mask_next;
    logic        halted_reg, halted_next;

    logic [3:0]  opcode;
    logic        fin;
    logic        op_ok;
    logic        cur_binary;
    logic        header_done;
    logic [31:0] room;
    logic        too_large;
    logic [2:0]  err;
    logic [7:0]  key_byte;

    assign cfg.ready = 1'b1;
    assign opcode    = first_byte_reg[3:0];
    assign fin       = first_byte_reg[7];

    assign op_ok = (opcode == wsdf_pkg::OP_CONT) || (opcode == wsdf_pkg::OP_TEXT) ||
                   (opcode == wsdf_pkg::OP_BINARY) || (opcode == wsdf_pkg::OP_CLOSE) ||
                   (opcode == wsdf_pkg::OP_PING) || (opcode == wsdf_pkg::OP_PONG);

    assign cur_binary = (opcode == wsdf_pkg::OP_CONT) ? frag_binary_reg
                                                      : (opcode == wsdf_pkg::OP_BINARY);

    always_comb
    begin
        case (mask_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        first_byte_next   = first_byte_reg;
        len_left_next     = len_left_reg;
        length_next       = length_reg;
        remaining_next    = remaining_reg;
        mask_present_next = mask_present_reg;
        mask_key_next     = mask_key_reg;
        mask_left_next    = mask_left_reg;
        mask_index_next   = mask_index_reg;
        header_size_next  = header_size_reg;
        frag_active_next  = frag_active_reg;
        frag_binary_next  = frag_binary_reg;
        frag_mask_next    = frag_mask_reg;
        halted_next       = halted_reg;
        header_done       = 1'b0;
        fire              = 1'b0;
        room              = '0;
        too_large         = 1'b0;
        err               = wsdf_pkg::ERR_NONE;
        result            = '0;
        result.frame_opcode = opcode;
        result.frame_final  = fin;

        if (advance && !halted_reg)
        begin
            case (phase_reg)
                PH_SECOND:
                begin
                    length_next       = {57'd0, byte_data[6:0]};
                    mask_present_next = byte_data[7];
                    header_size_next  = 4'd2;
                    len_left_next     = 4'd0;
                    if (byte_data[6:0] == wsdf_pkg::LEN_EXT16)
                    begin
                        len_left_next    = 4'd2;
                        header_size_next = 4'd4;
                        length_next      = '0;
                    end
                    else if (byte_data[6:0] == wsdf_pkg::LEN_EXT64)
                    begin
                        len_left_next    = 4'd8;
                        header_size_next = 4'd10;
                        length_next      = '0;
                    end
                    mask_left_next = 3'd0;
                    if (byte_data[7])
                    begin
                        mask_left_next   = 3'd4;
                        header_size_next = header_size_next + 4'd4;
                    end
                    if (len_left_next != 4'd0)
                    begin
                        phase_next = PH_EXTLEN;
                    end
                    else if (byte_data[7])
                    begin
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        header_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    length_next   = {length_reg[55:0], byte_data};
                    len_left_next = len_left_reg - 4'd1;
                    if (len_left_next == 4'd0)
                    begin
                        if (mask_present_reg)
                        begin
                            phase_next = PH_MASK;
                        end
                        else
                        begin
                            header_done = 1'b1;
                        end
                    end
                end
                PH_MASK:
                begin
                    mask_key_next  = {mask_key_reg[23:0], byte_data};
                    mask_left_next = mask_left_reg - 3'd1;
                    if (mask_left_next == 3'd0)
                    begin
                        header_done = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    mask_index_next      = mask_index_reg + 2'd1;
                    remaining_next       = remaining_reg - 64'd1;
                    fire                 = 1'b1;
                    result.kind          = wsdf_pkg::KIND_PAYLOAD;
                    result.data_byte     = byte_data ^ key_byte;
                    result.is_binary     = cur_binary;
                    result.last_of_frame = (remaining_reg == 64'd1);
                    if (remaining_reg == 64'd1)
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    first_byte_next  = byte_data;
                    header_size_next = 4'd2;
                    phase_next       = PH_SECOND;
                end
            endcase
        end

        if (header_done)
        begin
            room      = max_frame_reg - {28'd0, header_size_next};
            too_large = ({28'd0, header_size_next} > max_frame_reg) ||
                        (length_next[63:32] != 32'd0) || (length_next[31:0] > room);
            if (!op_ok)
            begin
                err = wsdf_pkg::ERR_OPCODE;
            end
            else if (too_large)
            begin
                err = wsdf_pkg::ERR_TOO_LARGE;
            end
            else if (!mask_present_next && !frag_active_reg)
            begin
                err = wsdf_pkg::ERR_UNMASKED;
            end
            else if ((opcode == wsdf_pkg::OP_CONT) && !frag_active_reg)
            begin
                err = wsdf_pkg::ERR_NO_START;
            end

            if (err != wsdf_pkg::ERR_NONE)
            begin
                fire              = 1'b1;
                result.kind       = wsdf_pkg::KIND_ERROR;
                result.error_code = err;
                halted_next       = 1'b1;
            end
            else
            begin
                if (!fin)
                begin
                    if (!frag_active_reg)
                    begin
                        frag_active_next = 1'b1;
                        frag_mask_next   = mask_key_next;
                        frag_binary_next = (opcode == wsdf_pkg::OP_BINARY);
                    end
                    else
                    begin
                        mask_key_next = frag_mask_reg;
                    end
                end
                else
                begin
                    if (!mask_present_next)
                    begin
                        mask_key_next = frag_mask_reg;
                    end
                    frag_active_next = 1'b0;
                end
                mask_index_next = 2'd0;
                remaining_next  = length_next;
                if (length_next == 64'd0)
                begin
                    fire                 = 1'b1;
                    result.kind          = wsdf_pkg::KIND_EMPTY;
                    result.is_binary     = (opcode == wsdf_pkg::OP_CONT) ? frag_binary_next
                                                                         : (opcode == wsdf_pkg::OP_BINARY);
                    result.last_of_frame = 1'b1;
                    phase_next           = PH_FIRST;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_FIRST;
            max_frame_reg    <= wsdf_pkg::MAX_FRAME_RESET;
            first_byte_reg   <= '0;
            len_left_reg     <= '0;
            length_reg       <= '0;
            remaining_reg    <= '0;
            mask_present_reg <= 1'b0;
            mask_key_reg     <= '0;
            mask_left_reg    <= '0;
            mask_index_reg   <= '0;
            header_size_reg  <= 4'd2;
            frag_active_reg  <= 1'b0;
            frag_binary_reg  <= 1'b0;
            frag_mask_reg    <= '0;
            halted_reg       <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            if (cfg.valid)
            begin
                max_frame_reg <= cfg.max_frame_size;
            end
            first_byte_reg   <= first_byte_next;
            len_left_reg     <= len_left_next;
            length_reg       <= length_next;
            remaining_reg    <= remaining_next;
            mask_present_reg <= mask_present_next;
            mask_key_reg     <= mask_key_next;
            mask_left_reg    <= mask_left_next;
            mask_index_reg   <= mask_index_next;
            header_size_reg  <= header_size_next;
            frag_active_reg  <= frag_active_next;
            frag_binary_reg  <= frag_binary_next;
            frag_mask_reg    <= frag_mask_next;
            halted_reg       <= halted_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/wsdf_out_stage.sv -----
// Result register that holds one parsed result until the consumer takes it.
`default_nettype none

module wsdf_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire wsdf_pkg::result_t  result,
    output logic                    can_take,
    wsdf_out_if.source              res
);

    logic              valid_reg;
    logic              valid_next;
    wsdf_pkg::result_t data_reg;

    assign can_take          = !valid_reg || res.ready;
    assign res.valid         = valid_reg;
    assign res.kind          = data_reg.kind;
    assign res.data_byte     = data_reg.data_byte;
    assign res.frame_opcode  = data_reg.frame_opcode;
    assign res.frame_final   = data_reg.frame_final;
    assign res.is_binary     = data_reg.is_binary;
    assign res.last_of_frame = data_reg.last_of_frame;
    assign res.error_code    = data_reg.error_code;

    always_comb
    begin
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the WebSocket frame deframer, with a byte-level frame predictor.
`timescale 1ns / 100ps

module testbench;
    import wsdf_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef enum logic [2:0] {AT_HEAD, AT_LEN, AT_EXTLEN, AT_KEY, AT_PAYLOAD} parse_step_t;
    typedef enum {LEN_SHORT, LEN_MID, LEN_LONG} len_form_t;

    class deframe_book;
        logic [31:0] max_size;
        parse_step_t step;
        logic [7:0]  head_byte;
        logic [3:0]  len_left;
        logic [63:0] pay_len;
        logic [63:0] pay_left;
        logic        masked;
        logic [31:0] key;
        logic [2:0]  key_left;
        logic [1:0]  key_idx;
        logic [3:0]  hdr_size;
        logic        frag_open;
        logic        frag_bin;
        logic [31:0] frag_key;
        logic        halted;
        result_t     awaited[$];
        int          errors;

        function new();
            max_size = MAX_FRAME_RESET;
            step = AT_HEAD;
            head_byte = 8'd0;
            len_left = 4'd0;
            pay_len = 64'd0;
            pay_left = 64'd0;
            masked = 1'b0;
            key = 32'd0;
            key_left = 3'd0;
            key_idx = 2'd0;
            hdr_size = 4'd2;
            frag_open = 1'b0;
            frag_bin = 1'b0;
            frag_key = 32'd0;
            halted = 1'b0;
            errors = 0;
        endfunction

        function logic data_binary();
            if (head_byte[3:0] == OP_CONT)
                return frag_bin;
            return head_byte[3:0] == OP_BINARY;
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] data, logic bin, logic last,
                                  logic [2:0] err);
            result_t r;
            r.kind = kind;
            r.data_byte = data;
            r.frame_opcode = head_byte[3:0];
            r.frame_final = head_byte[7];
            r.is_binary = bin;
            r.last_of_frame = last;
            r.error_code = err;
            awaited.insert(awaited.size(), r);
        endfunction

        function void close_header();
            logic [3:0] op;
            logic [2:0] err;
            op = head_byte[3:0];
            err = ERR_NONE;
            if (!(op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG}))
                err = ERR_OPCODE;
            else if (32'(hdr_size) > max_size || pay_len > 64'(max_size - 32'(hdr_size)))
                err = ERR_TOO_LARGE;
            else if (!masked && !frag_open)
                err = ERR_UNMASKED;
            else if (op == OP_CONT && !frag_open)
                err = ERR_NO_START;
            if (err != ERR_NONE)
            begin
                push_result(KIND_ERROR, 8'd0, 1'b0, 1'b0, err);
                halted = 1'b1;
                return;
            end
            if (!head_byte[7])
            begin
                if (!frag_open)
                begin
                    frag_open = 1'b1;
                    frag_key = key;
                    frag_bin = (op == OP_BINARY);
                end
                else
                begin
                    key = frag_key;
                end
            end
            else
            begin
                if (!masked)
                    key = frag_key;
                frag_open = 1'b0;
            end
            key_idx = 2'd0;
            pay_left = pay_len;
            if (pay_len == 64'd0)
            begin
                push_result(KIND_EMPTY, 8'd0, data_binary(), 1'b1, ERR_NONE);
                step = AT_HEAD;
            end
            else
            begin
                step = AT_PAYLOAD;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            logic [7:0] kb;
            if (halted)
                return;
            case (step)
                AT_LEN:
                begin
                    pay_len = 64'(b[6:0]);
                    masked = b[7];
                    hdr_size = 4'd2;
                    len_left = 4'd0;
                    if (b[6:0] == LEN_EXT16)
                    begin
                        len_left = 4'd2;
                        hdr_size = 4'd4;
                        pay_len = 64'd0;
                    end
                    else if (b[6:0] == LEN_EXT64)
                    begin
                        len_left = 4'd8;
                        hdr_size = 4'd10;
                        pay_len = 64'd0;
                    end
                    key_left = 3'd0;
                    if (masked)
                    begin
                        key_left = 3'd4;
                        hdr_size = hdr_size + 4'd4;
                    end
                    if (len_left != 4'd0)
                        step = AT_EXTLEN;
                    else if (masked)
                        step = AT_KEY;
                    else
                        close_header();
                end
                AT_EXTLEN:
                begin
                    pay_len = {pay_len[55:0], b};
                    len_left = len_left - 4'd1;
                    if (len_left == 4'd0)
                    begin
                        if (masked)
                            step = AT_KEY;
                        else
                            close_header();
                    end
                end
                AT_KEY:
                begin
                    key = {key[23:0], b};
                    key_left = key_left - 3'd1;
                    if (key_left == 3'd0)
                        close_header();
                end
                AT_PAYLOAD:
                begin
                    kb = key[8 * (3 - int'(key_idx)) +: 8];
                    key_idx = key_idx + 2'd1;
                    pay_left = pay_left - 64'd1;
                    push_result(KIND_PAYLOAD, b ^ kb, data_binary(), pay_left == 64'd0,
                                ERR_NONE);
                    if (pay_left == 64'd0)
                        step = AT_HEAD;
                end
                default:
                begin
                    head_byte = b;
                    hdr_size = 4'd2;
                    step = AT_LEN;
                end
            endcase
        endfunction

        function string show(result_t r);
            return $sformatf("kind %0d data %02h op %0d fin %0b bin %0b last %0b err %0d",
                             r.kind, r.data_byte, r.frame_opcode, r.frame_final,
                             r.is_binary, r.last_of_frame, r.error_code);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                got.frame_opcode !== want.frame_opcode ||
                got.frame_final !== want.frame_final || got.is_binary !== want.is_binary ||
                got.last_of_frame !== want.last_of_frame ||
                got.error_code !== want.error_code)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %s, got %s", show(want), show(got));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct = 22;
    int   bytes_sent = 0;
    int   quiet_cycles = 0;

    deframe_book book = new();

    wsdf_in_if  rx_ch ();
    wsdf_out_if res_ch ();
    wsdf_cfg_if cfg_ch ();

    websocket_frame_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_watch
        result_t got;
        if (rst_n === 1'b1 && res_ch.valid && res_ch.ready)
        begin
            got.kind = res_ch.kind;
            got.data_byte = res_ch.data_byte;
            got.frame_opcode = res_ch.frame_opcode;
            got.frame_final = res_ch.frame_final;
            got.is_binary = res_ch.is_binary;
            got.last_of_frame = res_ch.last_of_frame;
            got.error_code = res_ch.error_code;
            book.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        book.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input logic fin, input logic [3:0] op, input logic masked,
                               input logic [31:0] key, input logic [63:0] len,
                               input len_form_t form);
        send_byte({fin, 3'($urandom), op});
        case (form)
            LEN_SHORT:
                send_byte({masked, len[6:0]});
            LEN_MID:
            begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input logic [31:0] key, input int unsigned len,
                              input len_form_t form);
        send_header(fin, op, masked, key, 64'(len), form);
        repeat (len) send_byte(8'($urandom));
    endtask

    function automatic int unsigned header_bytes(len_form_t form, logic masked);
        return 2 + (form == LEN_MID ? 2 : (form == LEN_LONG ? 8 : 0)) + (masked ? 4 : 0);
    endfunction

    task automatic send_random_frame();
        logic        fin;
        logic [3:0]  op;
        logic        masked;
        int unsigned len;
        int unsigned hs;
        int unsigned pick;
        len_form_t   form;
        if (!book.frag_open)
        begin
            masked = 1'b1;
            case ($urandom_range(9))
                0, 1, 2, 3: op = OP_TEXT;
                4, 5, 6: op = OP_BINARY;
                7: op = OP_CLOSE;
                8: op = OP_PING;
                default: op = OP_PONG;
            endcase
            fin = ($urandom_range(99) < 65);
        end
        else
        begin
            masked = 1'($urandom_range(1));
            case ($urandom_range(9))
                7: op = OP_TEXT;
                8: op = OP_PING;
                9: op = OP_PONG;
                default: op = OP_CONT;
            endcase
            fin = ($urandom_range(99) < 35);
        end
        pick = $urandom_range(99);
        if (pick < 12)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(100, 140);
        pick = $urandom_range(99);
        if (len > 125)
        begin
            if (pick < 80)
                form = LEN_MID;
            else
                form = LEN_LONG;
        end
        else if (pick < 70)
            form = LEN_SHORT;
        else if (pick < 88)
            form = LEN_MID;
        else
            form = LEN_LONG;
        hs = header_bytes(form, masked);
        if (hs > book.max_size)
        begin
            form = LEN_SHORT;
            if (book.frag_open)
                masked = 1'b0;
            hs = header_bytes(form, masked);
            if (hs > book.max_size)
                return;
        end
        if (64'(len) + 64'(hs) > 64'(book.max_size))
            len = book.max_size - hs;
        if (form == LEN_SHORT && len > 125)
            len = 125;
        send_frame(fin, op, masked, $urandom, len, form);
    endtask

    task automatic settle();
        rx_ch.valid <= 1'b0;
        while (book.awaited.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.max_frame_size <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        book.max_size = v;
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] limits [6];
        logic [3:0]  bad_op;
        int          base;
        int          tries;
        int          err_pick;

        rst_n <= 1'b0;
        rx_ch.valid <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.max_frame_size <= 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Masked single frames, an empty frame, then a fragment that ends with an unmasked
        // continuation carrying the fragment's mask key.
        send_frame(1'b1, OP_TEXT, 1'b1, 32'hA5C3_0F81, 1, LEN_SHORT);
        send_frame(1'b1, OP_BINARY, 1'b1, 32'hFFFF_FFFF, 0, LEN_SHORT);
        send_frame(1'b0, OP_BINARY, 1'b1, 32'h3C5A_96E1, 1, LEN_MID);
        send_frame(1'b1, OP_CONT, 1'b0, 32'd0, 1, LEN_SHORT);
        settle();

        limits = '{32'hFFFF_FFFF, 32'd24, 32'd2, 32'd300, 32'($urandom), MAX_FRAME_RESET};
        for (int p = 0; p < 6; p++)
        begin
            // With a tiny size limit only unmasked frames inside an open fragment can pass.
            if (limits[p] < 32'd16 && !book.frag_open)
                send_frame(1'b0, OP_TEXT, 1'b1, $urandom, $urandom_range(3), LEN_SHORT);
            settle();
            write_limit(limits[p]);
            idle_pct = (p == 0) ? 0 : 22;
            base = bytes_sent;
            tries = 0;
            while (bytes_sent - base < 135 && tries < 300)
            begin
                tries++;
                send_random_frame();
                if ($urandom_range(99) < 4)
                    settle();
            end
        end

        // An error halts the block until reset, so exactly one kind is provoked at the end.
        if (book.frag_open)
            send_frame(1'b1, OP_CONT, 1'b1, $urandom, 0, LEN_SHORT);
        settle();
        err_pick = $urandom_range(1, 4);
        case (3'(err_pick))
            ERR_OPCODE:
            begin
                do bad_op = 4'($urandom);
                while (bad_op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
                send_header(1'b1, bad_op, 1'b1, $urandom, 64'd0, LEN_SHORT);
            end
            ERR_TOO_LARGE:
            begin
                write_limit(32'hFFFF_FFFF);
                send_header(1'b1, OP_BINARY, 1'b1, $urandom,
                            {32'($urandom) | 32'd1, 32'($urandom)}, LEN_LONG);
            end
            ERR_UNMASKED:
                send_header(1'b1, OP_TEXT, 1'b0, 32'd0, 64'($urandom_range(125)), LEN_SHORT);
            default:
                send_header(1'b1, OP_CONT, 1'b1, $urandom, 64'd3, LEN_SHORT);
        endcase
        repeat (12) send_byte(8'($urandom));
        settle();

        if (book.errors == 0 && book.awaited.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
